// ===== hw/rtl/ihex_pkg.sv =====
// Shared types and codes for the Intel HEX record parser.
// No dependencies; imported by every module of the block.
package ihex_pkg;

    localparam int PAYLOAD_DEPTH = 256;
    localparam int PAY_AW = $clog2(PAYLOAD_DEPTH);
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        ACT_CHAR  = 2'd0,
        ACT_DRAIN = 2'd1,
        ACT_END   = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        KIND_CONSUMED = 3'd0,
        KIND_RECORD   = 3'd1,
        KIND_DATA     = 3'd2,
        KIND_ERROR    = 3'd3,
        KIND_END      = 3'd4,
        KIND_BUSY     = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_MALFORMED = 3'd1,
        ERR_SPECIAL   = 3'd2,
        ERR_CHECKSUM  = 3'd3,
        ERR_AFTER_END = 3'd4
    } err_t;

    typedef enum logic [2:0] {
        PH_START,
        PH_AFTER,
        PH_COUNT,
        PH_ADDR,
        PH_TYPE,
        PH_PAYLOAD,
        PH_CHECK,
        PH_DONE
    } phase_t;

    localparam logic [7:0] REC_DATA = 8'h00;
    localparam logic [7:0] REC_EOF  = 8'h01;
    localparam logic [7:0] REC_ESA  = 8'h02;
    localparam logic [7:0] REC_SSA  = 8'h03;
    localparam logic [7:0] REC_ELA  = 8'h04;
    localparam logic [7:0] REC_SLA  = 8'h05;

    localparam logic [7:0] CH_COLON = 8'h3A;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] character;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  error_code;
        logic [31:0] byte_address;
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [7:0]  record_type;
        logic [7:0]  record_length;
        logic        checksum_ok;
    } out_item_t;

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A || c == 8'h0B;
    endfunction

    // bit 4 flags a valid hex digit
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
            r = {1'b1, c[3:0]};
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            r = {1'b1, c[3:0] + 4'd9};
        return r;
    endfunction

endpackage

// ===== hw/rtl/intel_hex_record_parser.sv =====
// Top level of the Intel HEX record parser: config register, front parser
// and result queue. Depends on ihex_pkg, ihex_front, ihex_back.
//
//   channel   direction  handshake            payload
//   in        input      push / full          in_item (action, character)
//   out       output     pop / empty          out_item (8 result fields)
//   cfg       input      cfg_valid/cfg_ready  cfg_data (ignore_checksum)
//
// One item per cycle while full is low; an item's result is held in the result
// register, then written into the queue, from which the consumer pops it.
// The parser next state is combinational; the payload memory read is registered.
// Reset clears all parse state; the payload memory is not cleared.
// full rises only when the result register waits on a full four-entry queue.
module intel_hex_record_parser import ihex_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_item_t  in_item,
    output logic      empty,
    input  logic      pop,
    output out_item_t out_item,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic      cfg_data
);

    logic      ign_reg;
    logic      res_valid;
    out_item_t res;
    logic      q_ready;
    logic      take;
    logic      accept;

    assign cfg_ready = 1'b1;
    assign take      = res_valid && q_ready;
    assign full      = res_valid && !q_ready;
    assign accept    = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ign_reg <= 1'b0;
        else if (cfg_valid)
            ign_reg <= cfg_data;
    end

    ihex_front u_front
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .ignore_checksum (ign_reg),
        .accept          (accept),
        .item            (in_item),
        .take            (take),
        .res_valid       (res_valid),
        .res             (res)
    );

    ihex_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (take),
        .wr_item (res),
        .ready   (q_ready),
        .pop     (pop),
        .empty   (empty),
        .head    (out_item)
    );

endmodule

// ===== hw/rtl/ihex_front.sv =====
// Front part: parses one character, drain or end request per beat, owns the
// payload memory and registers one result. Depends on ihex_pkg.
module ihex_front import ihex_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      ignore_checksum,
    input  logic      accept,
    input  in_item_t  item,
    input  logic      take,
    output logic      res_valid,
    output out_item_t res
);

    phase_t      phase_reg, phase_next;
    logic [2:0]  nib_reg, nib_next;
    logic [15:0] shift_reg, shift_next;
    logic [7:0]  count_reg, count_next;
    logic [15:0] addr_reg, addr_next;
    logic [7:0]  type_reg, type_next;
    logic [31:0] base_reg, base_next;
    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  fill_reg, fill_next;
    logic [7:0]  drain_reg, drain_next;
    logic [8:0]  pend_reg, pend_next;
    logic        end_reg, end_next;
    logic [2:0]  err_reg, err_next;
    logic        valid_reg, valid_next;
    out_item_t   res_reg, res_next;

    logic [7:0]  mem [PAYLOAD_DEPTH];
    logic [7:0]  rdata_reg;
    logic        wr_en, rd_en;

    logic [4:0]  hv;
    logic [2:0]  nib_inc;
    logic [15:0] shift_inc;
    logic [2:0]  need;
    logic [7:0]  expect_sum;
    logic        sum_ok;

    always_comb
    begin
        phase_next = phase_reg;
        nib_next   = nib_reg;
        shift_next = shift_reg;
        count_next = count_reg;
        addr_next  = addr_reg;
        type_next  = type_reg;
        base_next  = base_reg;
        sum_next   = sum_reg;
        fill_next  = fill_reg;
        drain_next = drain_reg;
        pend_next  = pend_reg;
        end_next   = end_reg;
        err_next   = err_reg;
        res_next   = '0;
        res_next.kind = KIND_CONSUMED;
        wr_en = 1'b0;
        rd_en = 1'b0;

        hv         = hex_val(item.character);
        nib_inc    = nib_reg + 3'd1;
        shift_inc  = {shift_reg[11:0], hv[3:0]};
        need       = (phase_reg == PH_ADDR) ? 3'd4 : 3'd2;
        expect_sum = 8'd0 - sum_reg;
        sum_ok     = shift_inc[7:0] == expect_sum;

        if (err_reg != ERR_NONE)
        begin
            res_next.kind = KIND_ERROR;
            res_next.error_code = err_reg;
        end
        else if (phase_reg == PH_DONE)
        begin
            res_next.kind = KIND_END;
        end
        else
        begin
            unique case (action_t'(item.action))
                ACT_CHAR:
                begin
                    if (pend_reg != 9'd0)
                        res_next.kind = KIND_BUSY;
                    else if (phase_reg == PH_START || phase_reg == PH_AFTER)
                    begin
                        if (phase_reg == PH_AFTER && is_space(item.character))
                            ;
                        else if (end_reg)
                            err_next = ERR_AFTER_END;
                        else if (item.character != CH_COLON)
                            err_next = ERR_MALFORMED;
                        else
                        begin
                            phase_next = PH_COUNT;
                            sum_next   = 8'd0;
                            nib_next   = 3'd0;
                            shift_next = 16'd0;
                        end
                    end
                    else if (!hv[4])
                        err_next = ERR_MALFORMED;
                    else
                    begin
                        shift_next = shift_inc;
                        nib_next   = nib_inc;
                        if (phase_reg != PH_CHECK && !nib_inc[0])
                            sum_next = sum_reg + shift_inc[7:0];
                        if (nib_inc >= need)
                        begin
                            nib_next = 3'd0;
                            unique case (phase_reg)
                                PH_COUNT:
                                begin
                                    count_next = shift_inc[7:0];
                                    shift_next = 16'd0;
                                    phase_next = PH_ADDR;
                                end
                                PH_ADDR:
                                begin
                                    addr_next  = shift_inc;
                                    shift_next = 16'd0;
                                    phase_next = PH_TYPE;
                                end
                                PH_TYPE:
                                begin
                                    type_next  = shift_inc[7:0];
                                    shift_next = 16'd0;
                                    if (shift_inc[7:0] == REC_EOF && count_reg != 8'd0)
                                        err_next = ERR_SPECIAL;
                                    else if ((shift_inc[7:0] == REC_ESA
                                              || shift_inc[7:0] == REC_ELA)
                                             && (count_reg != 8'd2 || addr_reg != 16'd0))
                                        err_next = ERR_SPECIAL;
                                    else if ((shift_inc[7:0] == REC_SSA
                                              || shift_inc[7:0] == REC_SLA)
                                             && (count_reg != 8'd4 || addr_reg != 16'd0))
                                        err_next = ERR_SPECIAL;
                                    else
                                    begin
                                        fill_next  = 8'd0;
                                        phase_next = (count_reg != 8'd0) ? PH_PAYLOAD
                                                                         : PH_CHECK;
                                    end
                                end
                                PH_PAYLOAD:
                                begin
                                    wr_en = (type_reg == REC_DATA);
                                    fill_next = fill_reg + 8'd1;
                                    if (fill_reg + 8'd1 == count_reg)
                                    begin
                                        if (type_reg == REC_ESA)
                                            base_next = {12'd0, shift_inc, 4'd0};
                                        if (type_reg == REC_ELA)
                                            base_next = {shift_inc, 16'd0};
                                        shift_next = 16'd0;
                                        phase_next = PH_CHECK;
                                    end
                                end
                                default:
                                begin
                                    shift_next = 16'd0;
                                    if (!sum_ok && !ignore_checksum)
                                        err_next = ERR_CHECKSUM;
                                    else
                                    begin
                                        if (type_reg == REC_EOF)
                                            end_next = 1'b1;
                                        if (type_reg == REC_DATA && count_reg != 8'd0)
                                        begin
                                            pend_next  = {1'b0, count_reg};
                                            drain_next = 8'd0;
                                        end
                                        phase_next = PH_AFTER;
                                        res_next.kind          = KIND_RECORD;
                                        res_next.record_type   = type_reg;
                                        res_next.record_length = count_reg;
                                        res_next.checksum_ok   = sum_ok;
                                    end
                                end
                            endcase
                        end
                    end
                end
                ACT_DRAIN:
                begin
                    if (pend_reg != 9'd0)
                    begin
                        rd_en = 1'b1;
                        res_next.kind = KIND_DATA;
                        res_next.byte_address = {16'd0, addr_reg} + base_reg
                                                + {24'd0, drain_reg};
                        if ({1'b0, drain_reg} + 9'd1 >= pend_reg)
                        begin
                            res_next.last_byte = 1'b1;
                            pend_next  = 9'd0;
                            drain_next = 8'd0;
                        end
                        else
                            drain_next = drain_reg + 8'd1;
                    end
                end
                ACT_END:
                begin
                    if (pend_reg != 9'd0)
                        res_next.kind = KIND_BUSY;
                    else if (phase_reg == PH_START || phase_reg == PH_AFTER)
                    begin
                        phase_next = PH_DONE;
                        res_next.kind = KIND_END;
                    end
                    else
                        err_next = ERR_MALFORMED;
                end
                default: ;
            endcase
            if (err_next != ERR_NONE)
            begin
                res_next = '0;
                res_next.kind = KIND_ERROR;
                res_next.error_code = err_next;
            end
        end

        if (accept)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            nib_reg   <= '0;
            shift_reg <= '0;
            count_reg <= '0;
            addr_reg  <= '0;
            type_reg  <= '0;
            base_reg  <= '0;
            sum_reg   <= '0;
            fill_reg  <= '0;
            drain_reg <= '0;
            pend_reg  <= '0;
            end_reg   <= 1'b0;
            err_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (accept)
            begin
                phase_reg <= phase_next;
                nib_reg   <= nib_next;
                shift_reg <= shift_next;
                count_reg <= count_next;
                addr_reg  <= addr_next;
                type_reg  <= type_next;
                base_reg  <= base_next;
                sum_reg   <= sum_next;
                fill_reg  <= fill_next;
                drain_reg <= drain_next;
                pend_reg  <= pend_next;
                end_reg   <= end_next;
                err_reg   <= err_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= res_next;
    end

    // payload memory; read data holds until the next drain beat that reads a byte
    always_ff @(posedge clk)
    begin
        if (accept && wr_en)
            mem[fill_reg[PAY_AW-1:0]] <= shift_inc[7:0];
        if (accept && rd_en)
            rdata_reg <= mem[drain_reg[PAY_AW-1:0]];
    end

    always_comb
    begin
        res = res_reg;
        if (res_reg.kind == KIND_DATA)
            res.data_byte = rdata_reg;
    end

    assign res_valid = valid_reg;

endmodule

// ===== hw/rtl/ihex_back.sv =====
// Back part: short result queue that presents the oldest result to the
// consumer. Depends on ihex_pkg.
module ihex_back import ihex_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr,
    input  out_item_t wr_item,
    output logic      ready,
    input  logic      pop,
    output logic      empty,
    output out_item_t head
);

    out_item_t           q_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wp_reg, wp_next;
    logic [QUEUE_AW-1:0] rp_reg, rp_next;
    logic [QUEUE_AW:0]   cnt_reg, cnt_next;
    logic                do_pop;

    assign ready  = cnt_reg != QUEUE_DEPTH[QUEUE_AW:0];
    assign empty  = cnt_reg == '0;
    assign do_pop = pop && !empty;
    assign head   = q_reg[rp_reg];

    always_comb
    begin
        wp_next  = wr ? wp_reg + 1'b1 : wp_reg;
        rp_next  = do_pop ? rp_reg + 1'b1 : rp_reg;
        cnt_next = cnt_reg + {{QUEUE_AW{1'b0}}, wr} - {{QUEUE_AW{1'b0}}, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            q_reg[wp_reg] <= wr_item;
    end

endmodule

// ===== tb/tb_intel_hex_record_parser.sv =====
// Testbench for intel_hex_record_parser: streams Intel HEX text with drain, end and
// no-op requests, predicts each result beat in-line and checks it field by field.
// Depends on ihex_pkg and the parser RTL.
module tb_intel_hex_record_parser;
    import ihex_pkg::*;

    localparam int HANG_LIMIT = 5000;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      push = 1'b0;
    logic      full;
    in_item_t  in_item = '0;
    logic      empty;
    logic      pop = 1'b0;
    out_item_t out_item;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic      cfg_data = 1'b0;

    intel_hex_record_parser dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .empty     (empty),
        .pop       (pop),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // parser state as predicted
    phase_t      phase = PH_START;
    int          nib = 0;
    logic [31:0] shift = '0;
    logic [7:0]  rec_count = '0;
    logic [15:0] rec_addr = '0;
    logic [7:0]  rec_type = '0;
    logic [31:0] base_offset = '0;
    logic [7:0]  csum = '0;
    logic [7:0]  payload [0:255];
    logic [7:0]  fill = '0;
    int          drain_idx = 0;
    int          pending = 0;
    bit          end_seen = 0;
    logic [2:0]  err_held = ERR_NONE;
    bit          ignore_sum = 0;

    out_item_t results_due[$];
    bit        failed = 0;
    int        items_sent = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        hold_left = 0;
    int        quiet_cycles = 0;

    function automatic int hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return -1;
    endfunction

    function automatic bit white(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A || c == 8'h0B;
    endfunction

    function automatic out_item_t raise_error(input logic [2:0] code);
        out_item_t r;
        r = '0;
        err_held = code;
        r.kind = KIND_ERROR;
        r.error_code = code;
        return r;
    endfunction

    function automatic out_item_t parse_char(input logic [7:0] c);
        out_item_t r;
        int d;
        int need;
        logic [7:0] want;
        r = '0;
        if (phase == PH_START || phase == PH_AFTER) begin
            if (phase == PH_AFTER && white(c)) return r;
            if (end_seen) return raise_error(ERR_AFTER_END);
            if (c != CH_COLON) return raise_error(ERR_MALFORMED);
            phase = PH_COUNT;
            csum = '0;
            nib = 0;
            shift = '0;
            return r;
        end
        d = hex_digit(c);
        if (d < 0) return raise_error(ERR_MALFORMED);
        shift = (shift << 4) | 32'(d);
        nib = (nib + 1) & 7;
        if (phase != PH_CHECK && nib[0] == 1'b0)
            csum = csum + shift[7:0];
        need = (phase == PH_ADDR) ? 4 : 2;
        if (nib < need) return r;
        nib = 0;
        case (phase)
            PH_COUNT:
            begin
                rec_count = shift[7:0];
                shift = '0;
                phase = PH_ADDR;
            end
            PH_ADDR:
            begin
                rec_addr = shift[15:0];
                shift = '0;
                phase = PH_TYPE;
            end
            PH_TYPE:
            begin
                rec_type = shift[7:0];
                shift = '0;
                if (rec_type == REC_EOF && rec_count != 0)
                    return raise_error(ERR_SPECIAL);
                if ((rec_type == REC_ESA || rec_type == REC_ELA) &&
                    (rec_count != 2 || rec_addr != 0))
                    return raise_error(ERR_SPECIAL);
                if ((rec_type == REC_SSA || rec_type == REC_SLA) &&
                    (rec_count != 4 || rec_addr != 0))
                    return raise_error(ERR_SPECIAL);
                fill = '0;
                phase = (rec_count != 0) ? PH_PAYLOAD : PH_CHECK;
            end
            PH_PAYLOAD:
            begin
                if (rec_type == REC_DATA)
                    payload[fill] = shift[7:0];
                fill = fill + 8'd1;
                if (fill == rec_count) begin
                    if (rec_type == REC_ESA) base_offset = {12'h0, shift[15:0], 4'h0};
                    if (rec_type == REC_ELA) base_offset = {shift[15:0], 16'h0};
                    shift = '0;
                    phase = PH_CHECK;
                end
            end
            default:
            begin
                want = 8'h00 - csum;
                r.checksum_ok = (shift[7:0] == want);
                shift = '0;
                if (!r.checksum_ok && !ignore_sum) return raise_error(ERR_CHECKSUM);
                if (rec_type == REC_EOF) end_seen = 1;
                if (rec_type == REC_DATA && rec_count != 0) begin
                    pending = rec_count;
                    drain_idx = 0;
                end
                phase = PH_AFTER;
                r.kind = KIND_RECORD;
                r.record_type = rec_type;
                r.record_length = rec_count;
            end
        endcase
        return r;
    endfunction

    function automatic out_item_t parse_step(input logic [1:0] act, input logic [7:0] c);
        out_item_t r;
        int idx;
        r = '0;
        if (err_held != ERR_NONE) begin
            r.kind = KIND_ERROR;
            r.error_code = err_held;
            return r;
        end
        if (phase == PH_DONE) begin
            r.kind = KIND_END;
            return r;
        end
        case (act)
            ACT_CHAR:
            begin
                if (pending != 0) r.kind = KIND_BUSY;
                else r = parse_char(c);
            end
            ACT_DRAIN:
            begin
                if (pending != 0) begin
                    idx = drain_idx & 255;
                    r.kind = KIND_DATA;
                    r.byte_address = {16'h0, rec_addr} + base_offset + 32'(idx);
                    r.data_byte = payload[idx];
                    if (idx + 1 >= pending) begin
                        r.last_byte = 1'b1;
                        pending = 0;
                        drain_idx = 0;
                    end else begin
                        drain_idx = idx + 1;
                    end
                end
            end
            ACT_END:
            begin
                if (pending != 0) begin
                    r.kind = KIND_BUSY;
                end else if (phase == PH_START || phase == PH_AFTER) begin
                    phase = PH_DONE;
                    r.kind = KIND_END;
                end else begin
                    r = raise_error(ERR_MALFORMED);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            failed = 1;
        end
    endfunction

    // result side: check every beat, random stalls, long hold-off, hang watchdog
    always @(posedge clk) begin
        out_item_t want;
        if (pop && !empty) begin
            if (results_due.size() == 0) begin
                $error("result beat with nothing expected: kind %0d", out_item.kind);
                failed = 1;
            end else begin
                want = results_due.pop_front();
                check_field("kind", want.kind, out_item.kind);
                check_field("error_code", want.error_code, out_item.error_code);
                check_field("byte_address", want.byte_address, out_item.byte_address);
                check_field("data_byte", want.data_byte, out_item.data_byte);
                check_field("last_byte", want.last_byte, out_item.last_byte);
                check_field("record_type", want.record_type, out_item.record_type);
                check_field("record_length", want.record_length, out_item.record_length);
                check_field("checksum_ok", want.checksum_ok, out_item.checksum_ok);
            end
        end
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= HANG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
        if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_item(input action_t act, input logic [7:0] c);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        in_item <= '{action: act, character: c};
        @(posedge clk);
        while (full) @(posedge clk);
        results_due.push_back(parse_step(act, c));
        items_sent++;
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (results_due.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_ignore_checksum(input bit v);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        ignore_sum = v;
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 10) return 8'h30 + n;
        return ($urandom_range(1) ? 8'h61 : 8'h41) + n - 8'd10;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        send_item(ACT_CHAR, hex_char(b[7:4]));
        send_item(ACT_CHAR, hex_char(b[3:0]));
    endtask

    // fixed supplies the payload (msb first) when use_fixed is set
    task automatic send_record(input logic [7:0] typ, input logic [7:0] cnt,
                               input logic [15:0] addr, input bit bad_sum,
                               input bit use_fixed = 0, input logic [31:0] fixed = 0);
        logic [7:0] sum;
        logic [7:0] b;
        send_item(ACT_CHAR, CH_COLON);
        sum = cnt + addr[15:8] + addr[7:0] + typ;
        send_byte(cnt);
        send_byte(addr[15:8]);
        send_byte(addr[7:0]);
        send_byte(typ);
        for (int i = 0; i < cnt; i++) begin
            b = use_fixed ? fixed[8 * (cnt - 1 - i) +: 8] : 8'($urandom);
            sum = sum + b;
            send_byte(b);
        end
        sum = 8'h00 - sum;
        if (bad_sum) sum = sum ^ (8'h01 << $urandom_range(7));
        send_byte(sum);
    endtask

    task automatic send_white();
        logic [7:0] ws [5] = '{8'h20, 8'h09, 8'h0D, 8'h0A, 8'h0B};
        repeat ($urandom_range(2)) send_item(ACT_CHAR, ws[$urandom_range(4)]);
    endtask

    // drain a buffered record, with refused characters and end requests mixed in
    task automatic drain_bytes(input int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) == 0)
                send_item(action_t'($urandom_range(1) ? ACT_END : ACT_CHAR), 8'($urandom));
            send_item(ACT_DRAIN, 8'($urandom));
        end
        if ($urandom_range(7) == 0) send_item(ACT_DRAIN, 8'($urandom));
    endtask

    task automatic random_record();
        int pick;
        logic [7:0] cnt;
        bit bad;
        pick = $urandom_range(99);
        bad = ignore_sum && ($urandom_range(3) == 0);
        if (pick < 70) begin
            cnt = ($urandom_range(49) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(12));
            send_record(REC_DATA, cnt, 16'($urandom), bad);
            send_white();
            drain_bytes(cnt);
        end else if (pick < 78) begin
            send_record(REC_ELA, 2, 0, bad);
        end else if (pick < 84) begin
            send_record(REC_ESA, 2, 0, bad);
        end else if (pick < 90) begin
            send_record($urandom_range(1) ? REC_SSA : REC_SLA, 4, 0, bad);
        end else begin
            send_record(8'($urandom_range(255, 6)), 8'($urandom_range(6)), 16'($urandom), bad);
        end
        send_white();
        if ($urandom_range(19) == 0) send_item(ACT_DRAIN, 8'($urandom));
        if ($urandom_range(19) == 0) send_item(ACT_NONE, 8'($urandom));
    endtask

    task automatic test_directed();
        send_record(REC_DATA, 0, 16'h0000, 0);
        send_record(REC_ELA, 2, 0, 0, 1, 32'hFFFF);
        send_record(REC_DATA, 2, 16'hFFFF, 0);     // address wraps past 2^32
        send_item(ACT_CHAR, 8'hFF);
        send_item(ACT_END, 8'h00);
        send_item(ACT_DRAIN, 8'h00);
        send_item(ACT_DRAIN, 8'h00);
        send_item(ACT_DRAIN, 8'h00);
        send_item(ACT_NONE, 8'hFF);
        send_item(ACT_CHAR, 8'h20);
        send_item(ACT_CHAR, 8'h09);
        send_item(ACT_CHAR, 8'h0D);
        send_item(ACT_CHAR, 8'h0A);
        send_item(ACT_CHAR, 8'h0B);
        send_record(REC_ESA, 2, 0, 0, 1, 32'hFFFF);
        send_record(REC_DATA, 1, 16'h0000, 0);
        drain_bytes(1);
        send_record(REC_SSA, 4, 0, 0);
        send_record(REC_SLA, 4, 0, 0);
        send_record(8'hFF, 3, 16'h1234, 0);
        send_record(REC_ELA, 2, 0, 0, 1, 32'h0000);
    endtask

    task automatic test_checksum_override();
        set_ignore_checksum(1);
        send_record(REC_DATA, 3, 16'h8000, 1);
        drain_bytes(3);
        send_record(REC_ELA, 2, 0, 1);
        send_record(REC_DATA, 1, 16'h0001, 0);
        drain_bytes(1);
        set_ignore_checksum(0);
    endtask

    task automatic test_random_traffic();
        int send_pct [4] = '{0, 64, 0, 26};
        int recv_pct [4] = '{0, 0, 64, 26};
        int stop_at;
        for (int m = 0; m < 4; m++) begin
            if (m == 2) set_ignore_checksum(1);
            if (m == 3) set_ignore_checksum(0);
            send_idle_pct = send_pct[m];
            recv_stall_pct = recv_pct[m];
            stop_at = items_sent + 225;
            while (items_sent < stop_at) random_record();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    task automatic test_backpressure();
        hold_left = 300;
        send_record(REC_DATA, 16, 16'h4000, 0);
        drain_bytes(16);
        wait_drained();
        send_record(REC_DATA, 2, 16'h0010, 0);
        drain_bytes(2);
    endtask

    // errors and the end of input are sticky, so only one of them per run
    task automatic test_terminal();
        case ($urandom_range(6))
            0:
            begin
                send_record(REC_EOF, 0, 0, 0);
                send_white();
                send_item(ACT_END, 8'h00);
            end
            1: send_item(ACT_END, 8'h00);
            2:
            begin
                send_item(ACT_CHAR, CH_COLON);
                send_item(ACT_CHAR, "G");
            end
            3:
            begin
                send_item(ACT_CHAR, CH_COLON);
                send_byte(8'h10);
                send_item(ACT_END, 8'h00);
            end
            4: send_record(REC_ELA, 1, 16'h0000, 0);
            5: send_record(REC_DATA, 2, 16'h0100, 1);
            default:
            begin
                send_record(REC_EOF, 0, 0, 0);
                send_item(ACT_CHAR, CH_COLON);
            end
        endcase
        repeat (4) send_item(action_t'($urandom_range(3)), 8'($urandom));
    endtask

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_checksum_override();
        test_random_traffic();
        test_backpressure();
        test_terminal();
        wait_drained();
        repeat (10) @(posedge clk);
        if (!failed)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
